/* hw/rtl/hdr_filmic_tonemap_gamma_defines.svh */
// assertion helpers shared by the checker
`ifndef HDR_FILMIC_TONEMAP_GAMMA_DEFINES_SVH
`define HDR_FILMIC_TONEMAP_GAMMA_DEFINES_SVH

// property checked outside reset
`define HFTG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hftg check failed");

// property that also holds through reset
`define HFTG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("hftg check failed");

`endif

/* hw/rtl/hftg_pkg.sv */
package hftg_pkg;

    localparam int LIN_W  = 24;
    localparam int CODE_W = 8;
    localparam int IDX_W  = 8;

    localparam logic [IDX_W-1:0] IDX_EXPOSURE = 8'd0;
    localparam logic [IDX_W-1:0] IDX_FILMIC   = 8'd1;
    localparam logic [IDX_W-1:0] IDX_BYPASS   = 8'd2;

    typedef struct packed {
        logic signed [7:0] exposure_sixteenths;
        logic              filmic_enable;
        logic              gamma_bypass;
    } t_cfg;

    // 2^(i/16) in 1/65536 units
    function automatic logic [16:0] exp_mant(input logic [3:0] i);
        logic [16:0] m;
        unique case (i)
            4'd0:  m = 17'd65536;
            4'd1:  m = 17'd68438;
            4'd2:  m = 17'd71468;
            4'd3:  m = 17'd74632;
            4'd4:  m = 17'd77936;
            4'd5:  m = 17'd81386;
            4'd6:  m = 17'd84990;
            4'd7:  m = 17'd88752;
            4'd8:  m = 17'd92682;
            4'd9:  m = 17'd96785;
            4'd10: m = 17'd101070;
            4'd11: m = 17'd105546;
            4'd12: m = 17'd110218;
            4'd13: m = 17'd115098;
            4'd14: m = 17'd120194;
            default: m = 17'd125515;
        endcase
        return m;
    endfunction

    // smallest index i with 255^11 * i^5 >= k^11 * 2^(5*l), evaluated at elaboration
    function automatic logic [16:0] gamma_thr(input int k, input int l);
        logic [191:0] base;
        logic [191:0] rhs;
        logic [191:0] lhs;
        int lo;
        int hi;
        int mid;
        base = 192'd1;
        rhs  = 192'd1;
        for (int n = 0; n < 11; n++) begin
            base = base * 192'd255;
            rhs  = rhs * 192'(k);
        end
        rhs = rhs << (5 * l);
        lo  = 0;
        hi  = 1 << l;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            lhs = base;
            for (int n = 0; n < 5; n++) lhs = lhs * 192'(mid);
            if (lhs >= rhs) hi = mid;
            else lo = mid + 1;
        end
        if (k == 0) lo = 0;
        return 17'(lo);
    endfunction

endpackage

/* hw/rtl/hftg_intf.sv */
interface hftg_pix_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] red_linear;
    logic [23:0] green_linear;
    logic [23:0] blue_linear;
    logic [23:0] alpha_linear;
    modport source (output valid, red_linear, green_linear, blue_linear, alpha_linear,
                    input ready);
    modport sink (input valid, red_linear, green_linear, blue_linear, alpha_linear,
                  output ready);
endinterface

interface hftg_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_code;
    logic [7:0] green_code;
    logic [7:0] blue_code;
    logic [7:0] alpha_code;
    modport source (output valid, red_code, green_code, blue_code, alpha_code,
                    input ready);
    modport sink (input valid, red_code, green_code, blue_code, alpha_code,
                  output ready);
endinterface

interface hftg_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/hdr_filmic_tonemap_gamma.sv */
// throughput: one pixel per cycle unless the output stalls; the lanes run a
// restoring divider and a gamma threshold search, each of one bit per stage
// a stalled output holds the whole pipeline; input ready is output free or taken
// reset clears the pipeline valids and sets exposure 0, filmic off, gamma 2.2
module hdr_filmic_tonemap_gamma #(
    parameter int FRAC_BITS      = 16,
    parameter int GAMMA_LUT_BITS = 12
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hftg_cfg_if.sink      i_cfg,
    hftg_pix_in_if.sink   i_pix,
    hftg_pix_out_if.source o_pix
);
    localparam int LAT = FRAC_BITS + 14;

    hftg_pkg::t_cfg r_cfg;
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                hftg_pkg::IDX_EXPOSURE: r_cfg.exposure_sixteenths <= i_cfg.data;
                hftg_pkg::IDX_FILMIC:   r_cfg.filmic_enable <= i_cfg.data[0];
                hftg_pkg::IDX_BYPASS:   r_cfg.gamma_bypass <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign w_en        = !r_vld[LAT-1] || o_pix.ready;
    assign i_pix.ready = w_en;
    assign o_pix.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_pix.valid};
        end
    end

    hftg_lane #(.FRAC_BITS(FRAC_BITS), .GAMMA_LUT_BITS(GAMMA_LUT_BITS)) u_red (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(r_cfg),
        .i_lin(i_pix.red_linear), .o_code(o_pix.red_code)
    );
    hftg_lane #(.FRAC_BITS(FRAC_BITS), .GAMMA_LUT_BITS(GAMMA_LUT_BITS)) u_green (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(r_cfg),
        .i_lin(i_pix.green_linear), .o_code(o_pix.green_code)
    );
    hftg_lane #(.FRAC_BITS(FRAC_BITS), .GAMMA_LUT_BITS(GAMMA_LUT_BITS)) u_blue (
        .i_clk(i_clk), .i_en(w_en), .i_cfg(r_cfg),
        .i_lin(i_pix.blue_linear), .o_code(o_pix.blue_code)
    );
    hftg_alpha #(.FRAC_BITS(FRAC_BITS), .LAT(LAT)) u_alpha (
        .i_clk(i_clk), .i_en(w_en),
        .i_alpha(i_pix.alpha_linear), .o_code(o_pix.alpha_code)
    );

endmodule

/* hw/rtl/hftg_lane.sv */
module hftg_lane #(
    parameter int FRAC_BITS      = 16,
    parameter int GAMMA_LUT_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  hftg_pkg::t_cfg      i_cfg,
    input  logic [23:0]         i_lin,
    output logic [7:0]          o_code
);
    localparam int F  = FRAC_BITS;
    localparam int L  = GAMMA_LUT_BITS;
    localparam int NW = 64;

    logic [L:0]    w_thr [256];
    logic [7:0]    w_off;
    logic [40:0]   r_prod;
    logic [3:0]    r_ip;
    logic [40:0]   w_sh;
    logic [23:0]   r_x;
    logic [47:0]   r_sq;
    logic [23:0]   r_x3;
    logic [NW-1:0] w_xs;
    logic [NW-1:0] r_rem [F+1];
    logic [NW-1:0] r_den [F+1];
    logic [F-1:0]  r_q   [F+1];
    logic [23:0]   r_xd  [F+1];
    logic          r_ge  [1:F];
    logic [24:0]   w_c;
    logic [24:0]   w_cc;
    logic [32:0]   w_cw;
    logic [7:0]    r_k   [9];
    logic [L:0]    r_si  [9];
    logic [L+8:0]  w_byp;

    for (genvar g = 0; g < 256; g++) begin : g_thr
        assign w_thr[g] = (L+1)'(hftg_pkg::gamma_thr(g, L));
    end

    // exposure: mantissa multiply, then shift by the integer stops
    assign w_off = i_cfg.exposure_sixteenths ^ 8'h80;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 41'(i_lin) * 41'(hftg_pkg::exp_mant(w_off[3:0]));
            r_ip   <= w_off[7:4];
        end
    end

    assign w_sh = r_prod >> (6'd24 - 6'(r_ip));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= (|w_sh[40:24]) ? 24'hFFFFFF : w_sh[23:0];
            r_sq <= 48'(r_x) * 48'(r_x);
            r_x3 <= r_x;
        end
    end

    assign w_xs = NW'(r_x3) << F;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= NW'(251) * NW'(r_sq) + NW'(3) * w_xs;
            r_den[0] <= NW'(243) * NW'(r_sq) + NW'(59) * w_xs
                        + NW'(14) * (NW'(1) << (2 * F));
            r_q[0]   <= '0;
            r_xd[0]  <= r_x3;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < F; j++) begin : g_div
        logic [NW-1:0] w_r2;
        logic          w_take;
        assign w_r2   = {r_rem[j][NW-2:0], 1'b0};
        assign w_take = (w_r2 >= r_den[j]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_take ? (w_r2 - r_den[j]) : w_r2;
                r_den[j+1] <= r_den[j];
                r_q[j+1]   <= {r_q[j][F-2:0], w_take};
                r_xd[j+1]  <= r_xd[j];
            end
        end
        if (j == 0) begin : g_ge0
            always_ff @(posedge i_clk) begin
                if (i_en) r_ge[1] <= (r_rem[0] >= r_den[0]);
            end
        end else begin : g_gen
            always_ff @(posedge i_clk) begin
                if (i_en) r_ge[j+1] <= r_ge[j];
            end
        end
    end

    // select curve output, clamp to one, reduce to table index
    always_comb begin
        if (i_cfg.filmic_enable) begin
            w_c = r_ge[F] ? (25'(1) << F) : 25'(r_q[F]);
        end else begin
            w_c = 25'(r_xd[F]);
        end
        w_cc = (w_c > (25'(1) << F)) ? (25'(1) << F) : w_c;
        if (L <= F) w_cw = 33'(w_cc) >> (F - L);
        else        w_cw = 33'(w_cc) << (L - F);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k[0]  <= '0;
            r_si[0] <= w_cw[L:0];
        end
    end

    // binary search of the gamma thresholds, one code bit per stage
    for (genvar b = 0; b < 8; b++) begin : g_srch
        logic [7:0] w_t;
        assign w_t = r_k[b] | (8'h80 >> b);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_k[b+1]  <= (w_thr[w_t] <= r_si[b]) ? w_t : r_k[b];
                r_si[b+1] <= r_si[b];
            end
        end
    end

    assign w_byp = {r_si[8], 8'b0} - (L+9)'(r_si[8]);

    always_ff @(posedge i_clk) begin
        if (i_en) o_code <= i_cfg.gamma_bypass ? w_byp[L+7:L] : r_k[8];
    end

endmodule

/* hw/rtl/hftg_alpha.sv */
module hftg_alpha #(
    parameter int FRAC_BITS = 16,
    parameter int LAT       = 30
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [23:0] i_alpha,
    output logic [7:0]  o_code
);
    logic [31:0] w_p;
    logic [31:0] w_s;
    logic [7:0]  r_dly [LAT];

    assign w_p = {i_alpha, 8'b0} - 32'(i_alpha);
    assign w_s = w_p >> FRAC_BITS;

    // align with the color lanes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= (|w_s[31:8]) ? 8'hFF : w_s[7:0];
            for (int i = 1; i < LAT; i++) r_dly[i] <= r_dly[i-1];
        end
    end

    assign o_code = r_dly[LAT-1];

endmodule

/* hw/rtl/hftg_checker.sv */
`include "hdr_filmic_tonemap_gamma_defines.svh"

module hftg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_ready,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);
    // a stalled transaction holds
    `HFTG_ASSERT(a_out_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
    `HFTG_ASSERT(a_in_ready, i_clk, i_rst_n, i_in_ready == (!i_out_valid || i_out_ready))
    `HFTG_ASSERT(a_cfg_ready, i_clk, i_rst_n, i_cfg_ready)
    `HFTG_ASSERT_ALWAYS(a_rst_flush, i_clk, !i_rst_n |=> !i_out_valid)
endmodule

bind hdr_filmic_tonemap_gamma hftg_checker u_hftg_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_cfg_ready(i_cfg.ready),
    .i_in_ready(i_pix.ready),
    .i_out_valid(o_pix.valid),
    .i_out_ready(o_pix.ready),
    .i_out_data({o_pix.red_code, o_pix.green_code, o_pix.blue_code, o_pix.alpha_code})
);
